FILE: design/jsle_pkg.sv
package jsle_pkg;

  // Longest expansion of one item: opening quote, held prefix, a six-character
  // escape, closing quote. An opening quote clears any held prefix, so the
  // practical maximum is nine, but ten slots keep the packing simple.
  localparam int unsigned MaxChars  = 10;
  localparam int unsigned CntWidth  = $clog2(MaxChars + 1);
  localparam int unsigned BodyChars = 6;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChReturn    = 8'h0d;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLess      = 8'h3c;
  localparam logic [7:0] ChGreater   = 8'h3e;
  localparam logic [7:0] ChAmp       = 8'h26;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChTwo       = 8'h32;
  localparam logic [7:0] ChEight     = 8'h38;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChLowerN    = 8'h6e;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] CtrlLimit   = 8'h20;

  localparam logic [7:0] ByteE2 = 8'he2;
  localparam logic [7:0] Byte80 = 8'h80;
  localparam logic [7:0] ByteA8 = 8'ha8;
  localparam logic [7:0] ByteA9 = 8'ha9;

  // Held UTF-8 prefix.
  localparam logic [1:0] PhaseNone = 2'd0;
  localparam logic [1:0] PhaseE2   = 2'd1;
  localparam logic [1:0] PhaseE280 = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       first_of_string;
    logic       last_of_string;
  } jsle_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       literal_end;
  } jsle_out_t;

  // One classified item: its characters in output order, slot 0 first.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [CntWidth-1:0]      cnt;
    logic                     close;
  } jsle_job_t;

  typedef struct packed {
    logic [BodyChars-1:0][7:0] chars;
    logic [2:0]                len;
  } jsle_body_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (ChZero + {4'd0, v}) : (8'h57 + {4'd0, v});
  endfunction

  // Escaped form of one ordinary byte (never called for the E2 lead byte).
  function automatic jsle_body_t escape_byte(input logic [7:0] b);
    jsle_body_t r;
    r = '0;
    unique case (b)
      ChQuote, ChBackslash: begin
        r.chars[0] = ChBackslash;
        r.chars[1] = b;
        r.len      = 3'd2;
      end
      ChNewline: begin
        r.chars[0] = ChBackslash;
        r.chars[1] = ChLowerN;
        r.len      = 3'd2;
      end
      ChReturn: begin
        r.chars[0] = ChBackslash;
        r.chars[1] = ChLowerR;
        r.len      = 3'd2;
      end
      ChTab: begin
        r.chars[0] = ChBackslash;
        r.chars[1] = ChLowerT;
        r.len      = 3'd2;
      end
      default: begin
        if (b < CtrlLimit || b == ChLess || b == ChGreater || b == ChAmp) begin
          // The byte's own lowercase hex value gives \u003c, \u003e and \u0026 as well.
          r.chars[0] = ChBackslash;
          r.chars[1] = ChLowerU;
          r.chars[2] = ChZero;
          r.chars[3] = ChZero;
          r.chars[4] = hex_digit(b[7:4]);
          r.chars[5] = hex_digit(b[3:0]);
          r.len      = 3'd6;
        end else begin
          r.chars[0] = b;
          r.len      = 3'd1;
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: design/jsle_front.sv
module jsle_front
  import jsle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  jsle_in_t  item_i,
  output jsle_job_t job_o,
  output logic      job_valid_o
);

  logic [1:0] phase_q, phase_d;
  logic [1:0] phase_cur;
  logic [1:0] flush_a, flush_b;
  jsle_body_t body;
  jsle_job_t  job;
  logic [CntWidth-1:0] n;

  always_comb begin
    phase_cur = item_i.first_of_string ? PhaseNone : phase_q;
    phase_d   = phase_cur;
    flush_a   = 2'd0;
    flush_b   = 2'd0;
    body      = '0;

    if (item_i.has_byte) begin
      if (phase_cur == PhaseE2 && item_i.data_byte == Byte80) begin
        phase_d = PhaseE280;
      end else if (phase_cur == PhaseE280 &&
                   (item_i.data_byte == ByteA8 || item_i.data_byte == ByteA9)) begin
        body.chars[0] = ChBackslash;
        body.chars[1] = ChLowerU;
        body.chars[2] = ChTwo;
        body.chars[3] = ChZero;
        body.chars[4] = ChTwo;
        body.chars[5] = (item_i.data_byte == ByteA8) ? ChEight : ChNine;
        body.len      = 3'd6;
        phase_d       = PhaseNone;
      end else begin
        // Unused phase code three flushes nothing.
        flush_a = (phase_cur == PhaseE2) ? 2'd1 : (phase_cur == PhaseE280) ? 2'd2 : 2'd0;
        if (item_i.data_byte == ByteE2) begin
          phase_d = PhaseE2;
        end else begin
          body    = escape_byte(item_i.data_byte);
          phase_d = PhaseNone;
        end
      end
    end

    if (item_i.last_of_string) begin
      flush_b = (phase_d == PhaseE2) ? 2'd1 : (phase_d == PhaseE280) ? 2'd2 : 2'd0;
      phase_d = PhaseNone;
    end
  end

  // Pack the pieces into consecutive slots.
  always_comb begin
    job = '0;
    n   = '0;
    if (item_i.first_of_string) begin
      job.chars[n] = ChQuote;
      n = n + 1'b1;
    end
    if (flush_a != 2'd0) begin
      job.chars[n] = ByteE2;
      n = n + 1'b1;
    end
    if (flush_a == 2'd2) begin
      job.chars[n] = Byte80;
      n = n + 1'b1;
    end
    for (int i = 0; i < BodyChars; i++) begin
      if (3'(i) < body.len) begin
        job.chars[n] = body.chars[i];
        n = n + 1'b1;
      end
    end
    if (flush_b != 2'd0) begin
      job.chars[n] = ByteE2;
      n = n + 1'b1;
    end
    if (flush_b == 2'd2) begin
      job.chars[n] = Byte80;
      n = n + 1'b1;
    end
    if (item_i.last_of_string) begin
      job.chars[n] = ChQuote;
      n = n + 1'b1;
    end
    job.cnt   = n;
    job.close = item_i.last_of_string;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseNone;
    end else if (take_i) begin
      phase_q <= phase_d;
    end
  end

  assign job_o       = job;
  assign job_valid_o = take_i && (n != '0);

endmodule

FILE: design/jsle_fifo.sv
module jsle_fifo
  import jsle_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  jsle_job_t wdata_i,
  input  logic      rd_i,
  output jsle_job_t rdata_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW     = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

  jsle_job_t [Depth-1:0] mem_q;
  logic [PtrWidth-1:0] wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/jsle_back.sv
module jsle_back
  import jsle_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  jsle_job_t job_i,
  input  logic      job_avail_i,
  output logic      job_take_o,
  input  logic      pop_i,
  output logic      empty_o,
  output jsle_out_t result_o
);

  logic [MaxChars-1:0][7:0] chars_q;
  logic [CntWidth-1:0]      rem_q;
  logic                     close_q;
  logic                     done;

  assign empty_o    = (rem_q == '0);
  // The current job is finished when it is empty or its last character leaves now.
  assign done       = empty_o || (pop_i && rem_q == CntWidth'(1));
  assign job_take_o = done && job_avail_i;

  assign result_o.out_char    = chars_q[0];
  assign result_o.run_last    = (rem_q == CntWidth'(1));
  assign result_o.literal_end = close_q && (rem_q == CntWidth'(1));

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      chars_q <= job_i.chars;
      close_q <= job_i.close;
    end else if (pop_i && !empty_o) begin
      chars_q <= {8'h00, chars_q[MaxChars-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (job_take_o) begin
      rem_q <= job_i.cnt;
    end else if (pop_i && !empty_o) begin
      rem_q <= rem_q - 1'b1;
    end
  end

endmodule

FILE: design/js_string_literal_escaper.sv
// An accepted item is written into the job queue, and the output stage loads it from there
// when idle and presents its first result; results then leave one per cycle while pop is asserted.
// Throughput: one item per cycle at the input while the job queue has room; the output
// stage serializes one character per pop, so an item with n results holds it until all n leave.
// Reset (rst_ni low, asynchronous) clears the held prefix, the queue and the output stage.
module js_string_literal_escaper
  import jsle_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  jsle_in_t  item_i,
  input  logic      pop,
  output logic      empty,
  output jsle_out_t result_o
);

  // The front classifies each item into a packed list of output characters and
  // tracks the held UTF-8 prefix (E2 or E2 80) across items. Items that cause
  // no result, such as a held E2 in mid-string, never enter the queue.
  jsle_job_t front_job;
  logic      front_valid;
  logic      take;

  // A short queue decouples the classifier from the serializer, so the input
  // keeps flowing while a long escape sequence drains on the output side.
  jsle_job_t q_job;
  logic      q_full, q_empty;
  logic      q_take;

  // Full only reflects the queue, not the state of the output stage.
  assign full = q_full;
  assign take = push && !q_full;

  jsle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (item_i),
    .job_o       (front_job),
    .job_valid_o (front_valid)
  );

  jsle_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_valid),
    .wdata_i (front_job),
    .rd_i    (q_take),
    .rdata_o (q_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // The back stage holds the job being emitted and presents its oldest
  // character; it refills from the queue in the same cycle its last one leaves.
  jsle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_avail_i (!q_empty),
    .job_take_o  (q_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

endmodule
